// File: design/clipped_rect_fill_glyph_blitter_top_defines.svh
// Assertion macros used by the blitter engine RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef CLIPPED_RECT_FILL_GLYPH_BLITTER_TOP_DEFINES_SVH
`define CLIPPED_RECT_FILL_GLYPH_BLITTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CRFGB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");
`define CRFGB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define CRFGB_ASSERT(lbl, clk, rstn, prop)
`define CRFGB_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: design/crfgb_pkg.sv
// Package for the clipped rectangle fill and glyph blitter.
// Holds screen constants, command codes, structs and the engine state type.
package crfgb_pkg;

    localparam int SCREEN_W  = 320;
    localparam int SCREEN_H  = 200;
    localparam int GLYPH_MAX = 8;

    localparam int FB_DEPTH = SCREEN_W * SCREEN_H;
    localparam int ADDR_W   = $clog2(FB_DEPTH);
    localparam int COORD_W  = 10;
    localparam int COLOR_W  = 8;
    localparam int COUNT_W  = 16;
    localparam int GLYPH_W  = GLYPH_MAX * GLYPH_MAX;
    localparam int GIDX_W   = $clog2(GLYPH_MAX);

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 24;

    localparam logic [1:0] KIND_FILL  = 2'd0;
    localparam logic [1:0] KIND_GLYPH = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [10:0] pos_x;
        logic signed [10:0] pos_y;
        logic [9:0]         width;
        logic [9:0]         height;
        logic [7:0]         fg_color;
        logic [7:0]         bg_color;
        logic [GLYPH_W-1:0] glyph_bits;
    } t_cmd;

    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic [COUNT_W-1:0] pixels_written;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLIP,
        ST_ADDR,
        ST_DRAW,
        ST_READ,
        ST_RDATA,
        ST_DONE
    } t_eng_state;

endpackage

// File: design/crfgb_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Used for the frame store; no package dependencies.
module crfgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/crfgb_engine.sv
// Blitter engine: clipping, address generation and the frame store sequencer.
// Depends on crfgb_pkg, crfgb_ram and the assertion macro header.
`include "clipped_rect_fill_glyph_blitter_top_defines.svh"

module crfgb_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  crfgb_pkg::t_cmd   i_cmd,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output crfgb_pkg::t_result o_res
);
    import crfgb_pkg::*;

    localparam logic [ADDR_W-1:0]        FB_LAST   = ADDR_W'(FB_DEPTH - 1);
    localparam logic [ADDR_W-1:0]        ROW_STEP  = ADDR_W'(SCREEN_W);
    localparam logic [COORD_W-1:0]       SCREEN_WL = COORD_W'(SCREEN_W);
    localparam logic signed [11:0]       SCREEN_WS = 12'(SCREEN_W);
    localparam logic signed [11:0]       SCREEN_HS = 12'(SCREEN_H);
    localparam logic [9:0]               GMAX      = 10'(GLYPH_MAX);

    t_eng_state r_state, n_state;
    t_cmd       r_cmd, n_cmd;

    logic [COORD_W-1:0] r_cs, n_cs;
    logic [COORD_W-1:0] r_rs, n_rs;
    logic [COORD_W-1:0] r_ew, n_ew;
    logic [COORD_W-1:0] r_eh, n_eh;
    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic               r_go, n_go;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [ADDR_W-1:0]  r_row_base, n_row_base;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COLOR_W-1:0] r_color, n_color;

    logic signed [11:0] x_s, y_s, x_end, y_end, x1, y1, x_span, y_span;
    logic [COORD_W-1:0] x0, y0, fill_ew, fill_eh;
    logic               glyph_ok, read_ok;
    logic [2*COORD_W-1:0] area;
    logic [2*COORD_W-1:0] base_prod;
    logic [GIDX_W*2-1:0]  gidx;
    logic                 gbit;

    logic               ram_we;
    logic [COLOR_W-1:0] ram_wdata;
    logic [COLOR_W-1:0] ram_rdata;

    crfgb_ram #(
        .WIDTH(COLOR_W),
        .DEPTH(FB_DEPTH)
    ) u_frame_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (r_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        x_s     = {r_cmd.pos_x[10], r_cmd.pos_x};
        y_s     = {r_cmd.pos_y[10], r_cmd.pos_y};
        x_end   = x_s + signed'({2'b00, r_cmd.width});
        y_end   = y_s + signed'({2'b00, r_cmd.height});
        x0      = r_cmd.pos_x[10] ? '0 : r_cmd.pos_x[9:0];
        y0      = r_cmd.pos_y[10] ? '0 : r_cmd.pos_y[9:0];
        x1      = (x_end > SCREEN_WS) ? SCREEN_WS : x_end;
        y1      = (y_end > SCREEN_HS) ? SCREEN_HS : y_end;
        x_span  = x1 - signed'({2'b00, x0});
        y_span  = y1 - signed'({2'b00, y0});
        fill_ew = (x_span > 12'sd0) ? x_span[9:0] : '0;
        fill_eh = (y_span > 12'sd0) ? y_span[9:0] : '0;
        glyph_ok = (r_cmd.width != '0) && (r_cmd.width <= GMAX)
                && (r_cmd.height != '0) && (r_cmd.height <= GMAX)
                && !r_cmd.pos_x[10] && !r_cmd.pos_y[10]
                && (x_end <= SCREEN_WS) && (y_end <= SCREEN_HS);
        read_ok = !r_cmd.pos_x[10] && !r_cmd.pos_y[10]
               && (x_s < SCREEN_WS) && (y_s < SCREEN_HS);

        area      = r_ew * r_eh;
        base_prod = r_rs * SCREEN_WL;
        gidx      = {r_row[GIDX_W-1:0], ~r_col[GIDX_W-1:0]};
        gbit      = r_cmd.glyph_bits[gidx];
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_cs       = r_cs;
        n_rs       = r_rs;
        n_ew       = r_ew;
        n_eh       = r_eh;
        n_col      = r_col;
        n_row      = r_row;
        n_go       = r_go;
        n_addr     = r_addr;
        n_row_base = r_row_base;
        n_count    = r_count;
        n_color    = r_color;
        o_cmd_ready = 1'b0;
        o_res_valid = 1'b0;
        ram_we      = 1'b0;
        ram_wdata   = '0;

        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == FB_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd;
                    n_state = ST_CLIP;
                end
            end
            ST_CLIP: begin
                n_color = '0;
                n_cs    = x0;
                n_rs    = y0;
                case (r_cmd.kind)
                    KIND_FILL: begin
                        n_ew = fill_ew;
                        n_eh = fill_eh;
                        n_go = (fill_ew != '0) && (fill_eh != '0);
                    end
                    KIND_GLYPH: begin
                        n_ew = r_cmd.width;
                        n_eh = r_cmd.height;
                        n_go = glyph_ok;
                    end
                    KIND_READ: begin
                        n_ew = COORD_W'(1);
                        n_eh = COORD_W'(1);
                        n_go = read_ok;
                    end
                    default: begin
                        n_ew = '0;
                        n_eh = '0;
                        n_go = 1'b0;
                    end
                endcase
                n_state = ST_ADDR;
            end
            ST_ADDR: begin
                n_row_base = base_prod[ADDR_W-1:0] + ADDR_W'(r_cs);
                n_addr     = base_prod[ADDR_W-1:0] + ADDR_W'(r_cs);
                n_col      = '0;
                n_row      = '0;
                if (!r_go || (r_cmd.kind == KIND_READ)) begin
                    n_count = '0;
                end else if (|area[2*COORD_W-1:COUNT_W]) begin
                    n_count = '1;
                end else begin
                    n_count = area[COUNT_W-1:0];
                end
                if (!r_go) begin
                    n_state = ST_DONE;
                end else if (r_cmd.kind == KIND_READ) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: begin
                ram_we = 1'b1;
                if (r_cmd.kind == KIND_GLYPH) begin
                    ram_wdata = gbit ? r_cmd.fg_color : r_cmd.bg_color;
                end else begin
                    ram_wdata = r_cmd.fg_color;
                end
                if (r_col == r_ew - 1'b1) begin
                    n_col = '0;
                    if (r_row == r_eh - 1'b1) begin
                        n_state = ST_DONE;
                    end else begin
                        n_row      = r_row + 1'b1;
                        n_row_base = r_row_base + ROW_STEP;
                        n_addr     = r_row_base + ROW_STEP;
                    end
                end else begin
                    n_col  = r_col + 1'b1;
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_READ: begin
                n_state = ST_RDATA;
            end
            ST_RDATA: begin
                n_color = ram_rdata;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_cs       <= n_cs;
        r_rs       <= n_rs;
        r_ew       <= n_ew;
        r_eh       <= n_eh;
        r_col      <= n_col;
        r_row      <= n_row;
        r_go       <= n_go;
        r_row_base <= n_row_base;
        r_count    <= n_count;
        r_color    <= n_color;
    end

    assign o_res.read_color     = r_color;
    assign o_res.pixels_written = r_count;

    `CRFGB_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_state == ST_CLEAR))
    `CRFGB_ASSERT(a_draw_addr, i_clk, i_rst_n, (r_state == ST_DRAW) |-> (r_addr == r_row_base + ADDR_W'(r_col)))
    `CRFGB_ASSERT(a_draw_col, i_clk, i_rst_n, (r_state == ST_DRAW) |-> ((r_col < r_ew) && (r_row < r_eh)))
    `CRFGB_ASSERT(a_draw_bound, i_clk, i_rst_n, (r_state == ST_DRAW) |-> (r_addr <= FB_LAST))
    `CRFGB_ASSERT(a_done_idle, i_clk, i_rst_n, ((r_state == ST_DONE) && i_res_ready) |=> (r_state == ST_IDLE))

endmodule

// File: design/clipped_rect_fill_glyph_blitter_top.sv
// Top level of the clipped rectangle fill and glyph blitter with stream ports.
// Depends on crfgb_pkg and crfgb_engine; the result leaves through an output register.
//
// The blitter owns a 320x200 byte frame store and handles one command at a time.
// After reset it clears the frame store one byte per cycle and holds o_s_tready low
// until that is done. A fill or glyph command writes one pixel per cycle through the
// single frame store port. An accepted command passes the clip and address states,
// then the draw state for a fill or glyph or the read and read data states for a
// pixel read, and ends in the done state; a command that draws nothing goes from the
// address state straight to done. The result sits in an output register, so the
// next command is taken while the previous result still waits on o_m_tvalid; a
// second waiting result holds the engine and the input.
module clipped_rect_fill_glyph_blitter_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // kind, pos_x, pos_y, width, height, fg_color, bg_color, glyph_bits, zero pad
    input  logic [crfgb_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // read_color, pixels_written
    output logic [crfgb_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import crfgb_pkg::*;

    t_cmd    cmd;
    t_result eng_res;
    logic    eng_res_valid;
    logic    eng_res_ready;
    logic    r_out_valid;
    t_result r_out_data;

    assign cmd.kind       = i_s_tdata[1:0];
    assign cmd.pos_x      = i_s_tdata[12:2];
    assign cmd.pos_y      = i_s_tdata[23:13];
    assign cmd.width      = i_s_tdata[33:24];
    assign cmd.height     = i_s_tdata[43:34];
    assign cmd.fg_color   = i_s_tdata[51:44];
    assign cmd.bg_color   = i_s_tdata[59:52];
    assign cmd.glyph_bits = i_s_tdata[123:60];

    crfgb_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(i_s_tvalid),
        .o_cmd_ready(o_s_tready),
        .i_cmd      (cmd),
        .o_res_valid(eng_res_valid),
        .i_res_ready(eng_res_ready),
        .o_res      (eng_res)
    );

    assign eng_res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res_valid && eng_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_res_valid && eng_res_ready) begin
            r_out_data <= eng_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_data.pixels_written, r_out_data.read_color};

endmodule

// File: test/clipped_rect_fill_glyph_blitter_top_test.sv
// Self-checking testbench for the clipped rectangle fill and glyph blitter.
// Depends on crfgb_pkg and clipped_rect_fill_glyph_blitter_top; it keeps its own copy of
// the frame store and checks every result transaction against it.
`timescale 1ns / 1ps

module clipped_rect_fill_glyph_blitter_top_test;
    import crfgb_pkg::*;

    localparam logic [1:0] KIND_NOP = 2'd3;

    localparam int RANDOM_ITEMS = 1500;
    localparam int STALL_ITEMS  = 40;
    localparam int TAIL_ITEMS   = 260;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [M_TDATA_W-1:0]   o_m_tdata;

    logic [COLOR_W-1:0] frame_model [0:FB_DEPTH-1];
    t_result            pending_results [$];
    int                 mismatch_count = 0;
    bit                 idle_en        = 1'b1;
    int                 hold_request   = 0;

    clipped_rect_fill_glyph_blitter_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [S_TDATA_W-1:0] pack_cmd(input t_cmd c);
        return {4'b0, c.glyph_bits, c.bg_color, c.fg_color, c.height, c.width,
                c.pos_y, c.pos_x, c.kind};
    endfunction

    function automatic t_cmd make_cmd(input logic [1:0] kind, input int x, input int y,
                                      input int w, input int h, input int fg,
                                      input int bg, input logic [63:0] bits);
        t_cmd c;
        c.kind       = kind;
        c.pos_x      = 11'(x);
        c.pos_y      = 11'(y);
        c.width      = 10'(w);
        c.height     = 10'(h);
        c.fg_color   = 8'(fg);
        c.bg_color   = 8'(bg);
        c.glyph_bits = bits;
        return c;
    endfunction

    // Applies one command to the frame model and returns the result it must produce.
    function automatic t_result predict_blit(input t_cmd c);
        t_result     res;
        int          x, y, w, h, r, col, count;
        logic [7:0]  row;
        res   = '0;
        count = 0;
        x = int'($signed(c.pos_x));
        y = int'($signed(c.pos_y));
        w = int'(c.width);
        h = int'(c.height);
        case (c.kind)
            KIND_FILL: begin
                if (x < 0) begin
                    w = w + x;
                    x = 0;
                end
                if (y < 0) begin
                    h = h + y;
                    y = 0;
                end
                if (x + w > SCREEN_W) w = SCREEN_W - x;
                if (y + h > SCREEN_H) h = SCREEN_H - y;
                if (w > 0 && h > 0) begin
                    for (r = y; r < y + h; r++)
                        for (col = x; col < x + w; col++)
                            frame_model[r * SCREEN_W + col] = c.fg_color;
                    count = w * h;
                end
            end
            KIND_GLYPH: begin
                if (w <= GLYPH_MAX && h <= GLYPH_MAX && x >= 0 && y >= 0 &&
                    x + w <= SCREEN_W && y + h <= SCREEN_H) begin
                    for (r = 0; r < h; r++) begin
                        row = c.glyph_bits[8*r +: 8];
                        for (col = 0; col < w; col++) begin
                            frame_model[(y + r) * SCREEN_W + x + col] =
                                row[7-col] ? c.fg_color : c.bg_color;
                            count++;
                        end
                    end
                end
            end
            KIND_READ: begin
                if (x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H)
                    res.read_color = frame_model[y * SCREEN_W + x];
            end
            default: ;
        endcase
        res.pixels_written = (count > 65535) ? 16'hFFFF : 16'(count);
        return res;
    endfunction

    task automatic send_cmd(input t_cmd c);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pack_cmd(c);
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(predict_blit(c));
    endtask

    // Drops the input valid and waits until every expected result has come back.
    task automatic settle_blitter();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_cmd random_base();
        return make_cmd(2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), {$urandom(), $urandom()});
    endfunction

    function automatic t_cmd random_fill();
        t_cmd c;
        int   sel;
        c      = random_base();
        c.kind = KIND_FILL;
        sel    = $urandom_range(0, 199);
        if (sel == 0) begin
            c.pos_x  = 11'($urandom_range(0, 40) - 20);
            c.pos_y  = 11'($urandom_range(0, 40) - 20);
        end else if (sel < 4) begin
            c.kind = KIND_FILL;
        end else if (sel < 100) begin
            c.pos_x  = 11'($urandom_range(0, 67) - 4);
            c.pos_y  = 11'($urandom_range(0, 51) - 4);
            c.width  = 10'($urandom_range(0, 16));
            c.height = 10'($urandom_range(0, 16));
        end else begin
            c.pos_x  = 11'($urandom_range(0, 339) - 10);
            c.pos_y  = 11'($urandom_range(0, 219) - 10);
            c.width  = 10'($urandom_range(0, 24));
            c.height = 10'($urandom_range(0, 24));
        end
        return c;
    endfunction

    function automatic t_cmd random_glyph();
        t_cmd c;
        int   sel, w, h;
        c      = random_base();
        c.kind = KIND_GLYPH;
        sel    = $urandom_range(0, 99);
        if (sel < 85) begin
            w = $urandom_range(1, GLYPH_MAX);
            h = $urandom_range(1, GLYPH_MAX);
            if (sel < 50) begin
                c.pos_x = 11'($urandom_range(0, 56));
                c.pos_y = 11'($urandom_range(0, 40));
            end else begin
                c.pos_x = 11'($urandom_range(0, SCREEN_W - w));
                c.pos_y = 11'($urandom_range(0, SCREEN_H - h));
            end
            c.width  = 10'(w);
            c.height = 10'(h);
        end else if (sel < 95) begin
            c.pos_x  = 11'($urandom_range(0, 339) - 10);
            c.pos_y  = 11'($urandom_range(0, 219) - 10);
            c.width  = 10'($urandom_range(0, 12));
            c.height = 10'($urandom_range(0, 12));
        end
        return c;
    endfunction

    function automatic t_cmd random_read();
        t_cmd c;
        int   sel;
        c      = random_base();
        c.kind = KIND_READ;
        sel    = $urandom_range(0, 99);
        if (sel < 70) begin
            c.pos_x = 11'($urandom_range(0, 63));
            c.pos_y = 11'($urandom_range(0, 47));
        end else if (sel < 95) begin
            c.pos_x = 11'($urandom_range(0, SCREEN_W - 1));
            c.pos_y = 11'($urandom_range(0, SCREEN_H - 1));
        end
        return c;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            c = random_fill();
        end else if (sel < 70) begin
            c = random_glyph();
        end else if (sel < 97) begin
            c = random_read();
        end else begin
            c      = random_base();
            c.kind = KIND_NOP;
        end
        return c;
    endfunction

    task automatic test_read_after_reset();
        send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, '0));
        send_cmd(make_cmd(KIND_READ, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 0, 0, '0));
        settle_blitter();
    endtask

    task automatic test_fill_clipping();
        send_cmd(make_cmd(KIND_FILL, 0, 0, SCREEN_W, SCREEN_H, 8'hA5, 0, '0));
        send_cmd(make_cmd(KIND_FILL, 10, 10, 0, 5, 8'hFF, 0, '0));
        send_cmd(make_cmd(KIND_FILL, 10, 10, 5, 0, 8'hFF, 0, '0));
        send_cmd(make_cmd(KIND_FILL, -1024, -1024, 1023, 1023, 8'h11, 0, '1));
        send_cmd(make_cmd(KIND_FILL, -5, -3, 10, 10, 8'hFF, 8'hFF, '1));
        send_cmd(make_cmd(KIND_FILL, 315, 195, 1023, 1023, 8'h00, 0, '0));
        send_cmd(make_cmd(KIND_FILL, 1023, 0, 5, 5, 8'h33, 0, '0));
        send_cmd(make_cmd(KIND_FILL, 0, SCREEN_H, 5, 5, 8'h44, 0, '0));
        settle_blitter();
    endtask

    task automatic test_glyph_expand();
        send_cmd(make_cmd(KIND_GLYPH, 0, 0, 8, 8, 8'hFF, 8'h00, '1));
        send_cmd(make_cmd(KIND_GLYPH, SCREEN_W - 8, SCREEN_H - 8, 8, 8, 8'h00, 8'hFF, '0));
        send_cmd(make_cmd(KIND_GLYPH, SCREEN_W - 7, 0, 8, 8, 8'h12, 8'h34, '1));
        send_cmd(make_cmd(KIND_GLYPH, -1, 0, 8, 8, 8'h12, 8'h34, '1));
        send_cmd(make_cmd(KIND_GLYPH, 0, -1, 8, 8, 8'h12, 8'h34, '1));
        send_cmd(make_cmd(KIND_GLYPH, 10, 10, 9, 8, 8'h56, 8'h78, '1));
        send_cmd(make_cmd(KIND_GLYPH, 10, 10, 0, 5, 8'h56, 8'h78, '1));
        send_cmd(make_cmd(KIND_GLYPH, 20, 20, 3, 5, 8'h9A, 8'hBC,
                          {$urandom(), $urandom()}));
        settle_blitter();
    endtask

    task automatic test_read_pixel();
        send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, '0));
        send_cmd(make_cmd(KIND_READ, 7, 7, 1023, 1023, 8'hFF, 8'hFF, '1));
        send_cmd(make_cmd(KIND_READ, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 0, 0, '0));
        send_cmd(make_cmd(KIND_READ, -1, 0, 0, 0, 0, 0, '0));
        send_cmd(make_cmd(KIND_READ, SCREEN_W, 0, 0, 0, 0, 0, '0));
        send_cmd(make_cmd(KIND_READ, 0, SCREEN_H, 0, 0, 0, 0, '0));
        send_cmd(make_cmd(KIND_READ, -1024, -1024, 0, 0, 0, 0, '0));
        send_cmd(make_cmd(KIND_READ, 1023, 1023, 0, 0, 0, 0, '0));
        send_cmd(make_cmd(KIND_NOP, 4, 4, 8, 8, 8'hFF, 8'hFF, '1));
        settle_blitter();
    endtask

    task automatic test_random_mix();
        repeat (RANDOM_ITEMS) send_cmd(random_cmd());
        settle_blitter();
    endtask

    task automatic test_output_backpressure();
        hold_request = HOLD_CYCLES;
        repeat (STALL_ITEMS) begin
            if ($urandom_range(0, 1) == 0) send_cmd(random_read());
            else send_cmd(random_glyph());
        end
        settle_blitter();
    endtask

    task automatic test_no_idle();
        idle_en = 1'b0;
        repeat (TAIL_ITEMS) send_cmd(random_cmd());
        settle_blitter();
    endtask

    task automatic report_mismatch(input string what, input int expv, input int actv);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("Mismatch in %s: expected %0d, got %0d at %0t", what, expv, actv, $time);
    endtask

    // The receiver either honors a long hold, idles in short bursts, or accepts.
    initial begin
        int n;
        i_m_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                i_m_tready   <= 1'b0;
                n            = hold_request;
                hold_request = 0;
                repeat (n) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.read_color     = o_m_tdata[7:0];
            got.pixels_written = o_m_tdata[23:8];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Result transaction with no command pending at %0t", $time);
            end else begin
                want = pending_results.pop_front();
                if (got.read_color !== want.read_color)
                    report_mismatch("read_color", want.read_color, got.read_color);
                if (got.pixels_written !== want.pixels_written)
                    report_mismatch("pixels_written", want.pixels_written,
                                    got.pixels_written);
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        foreach (frame_model[i]) frame_model[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_read_after_reset();
        test_fill_clipping();
        test_glyph_expand();
        test_read_pixel();
        test_random_mix();
        test_output_backpressure();
        test_no_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/crfgb_pkg.sv
design/crfgb_ram.sv
design/crfgb_engine.sv
design/clipped_rect_fill_glyph_blitter_top.sv
test/clipped_rect_fill_glyph_blitter_top_test.sv
